// ===== src/ama_pkg.sv =====
// Shared types, constants and helpers for the alarm time matcher.
package ama_pkg;

	localparam int MAX_ALARMS_DEF = 8;
	localparam int CNT_W = 4;
	localparam int SLOT_W = 3;
	localparam int ONCE_BIT = 7;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_STOP  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       time_valid;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [2:0] weekday;
		logic       screen_on;
		logic       audio_playing;
		logic [2:0] entry_index;
		logic       entry_enabled;
		logic [7:0] entry_repeat;
	} in_t;

	typedef struct packed {
		logic       alarm_active;
		logic [2:0] active_index;
		logic       fired;
		logic       wake_screen;
		logic       play_sound;
		logic       show_alarm;
		logic       save_request;
	} out_t;

	typedef struct packed {
		logic       enabled;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [7:0] repeat_mask;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic load;
		logic exec;
		logic scan_step;
		logic take_hit;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic hit;
		logic scan_end;
		logic out_free;
	} ctl_sts_t;

	// Converts a Sunday-first weekday to the Monday-first bit position of the mask.
	function automatic logic [2:0] mon_first(input logic [2:0] wd);
		logic [2:0] res;
		res = 3'd6;
		if (wd != 3'd0 && wd != 3'd7) begin
			res = wd - 3'd1;
		end
		return res;
	endfunction

endpackage

// ===== src/alarm_time_matcher.sv =====
// Top level of the alarm time matcher: controller, datapath and checks.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  in      | request   | in_valid / in_stall  | in_data (ama_pkg::in_t)
//  out     | result    | out_valid / out_stall| out_data (ama_pkg::out_t)
//  cfg     | write     | cfg_we               | cfg_wdata (alarm count)
//
// A write, stop or non-scanning tick goes through decode and finish to the result register.
// A scanning tick reads the C slots in use one after another until one matches or all are
// read; the single read port of the table sets this.
// A new request is taken once the previous result sits in the output register.
// Reset clears the count, the ringing state and all handshake state; the table
// is left as is. A stalled result holds the next request in the finish state until taken.
module alarm_time_matcher #(
	parameter int MAX_ALARMS = ama_pkg::MAX_ALARMS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  ama_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output ama_pkg::out_t             out_data,
	input  logic                      cfg_we,
	input  logic [ama_pkg::CNT_W-1:0] cfg_wdata
);

	ama_pkg::ctl_cmd_t cmd;
	ama_pkg::ctl_sts_t sts;

	ama_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts(sts),
		.cmd(cmd)
	);

	ama_dp #(
		.MAX_ALARMS(MAX_ALARMS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd),
		.sts(sts),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// The block works on one request at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while previous one still in flight");

	a_fired_rings: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.fired) |-> out_data.alarm_active)
		else $error("fired result without an active alarm");

	a_save_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.save_request || out_data.wake_screen)) |-> out_data.fired)
		else $error("save or wake request without a trigger");

	a_sound_on_show: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.play_sound) |-> (out_data.show_alarm && !out_data.fired))
		else $error("sound request outside a ringing tick");

endmodule

// ===== src/ama_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ama_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/ama_dp.sv =====
// Datapath: request register, alarm table, scan pipeline, ringing state and result register.
module ama_dp #(
	parameter int MAX_ALARMS = ama_pkg::MAX_ALARMS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ama_pkg::in_t            in_data,
	input  logic                    cfg_we,
	input  logic [ama_pkg::CNT_W-1:0] cfg_wdata,
	input  ama_pkg::ctl_cmd_t       cmd,
	output ama_pkg::ctl_sts_t       sts,
	output logic                    out_valid,
	input  logic                    out_stall,
	output ama_pkg::out_t           out_data
);

	localparam int AW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;

	ama_pkg::in_t              item_q;
	logic [ama_pkg::CNT_W-1:0] alarm_count_q;
	logic [ama_pkg::CNT_W-1:0] count_sat;
	logic [ama_pkg::CNT_W-1:0] issue_q;
	logic [ama_pkg::CNT_W-1:0] chk_q;
	logic                      rd_vld_q;
	logic                      issue_lt;
	logic                      ringing_q;
	logic [ama_pkg::SLOT_W-1:0] slot_q;
	logic                      fired_q;
	logic                      wake_q;
	logic                      save_q;
	logic                      show_q;
	logic                      sound_q;
	logic                      out_vld_q;
	ama_pkg::out_t             out_q;

	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [ama_pkg::ENTRY_W-1:0] wr_data;
	logic                      rd_en;
	logic [ama_pkg::ENTRY_W-1:0] rd_data;
	ama_pkg::entry_t           ent;
	ama_pkg::entry_t           new_ent;
	ama_pkg::entry_t           dis_ent;
	logic [2:0]                wday;
	logic                      day_hit;
	logic                      ent_match;
	logic                      once_only;
	logic                      is_tick;
	logic                      ring_tick;
	logic                      write_ok;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_count_q <= '0;
		end else if (cfg_we) begin
			alarm_count_q <= cfg_wdata;
		end
	end

	always_comb begin
		count_sat = alarm_count_q;
		if (32'(alarm_count_q) > MAX_ALARMS) begin
			count_sat = ama_pkg::CNT_W'(MAX_ALARMS);
		end
	end

	assign is_tick = (item_q.opcode == ama_pkg::OP_TICK) && (count_sat != '0);
	assign ring_tick = is_tick && ringing_q;
	assign issue_lt = issue_q < count_sat;
	assign write_ok = (item_q.opcode == ama_pkg::OP_WRITE) &&
		(32'(item_q.entry_index) < MAX_ALARMS);

	// Entry compare on the registered read data of the slot in chk_q.
	assign ent = ama_pkg::entry_t'(rd_data);
	assign wday = ama_pkg::mon_first(item_q.weekday);
	assign day_hit = ent.repeat_mask[wday];
	assign ent_match = ent.enabled && (ent.hour == item_q.hour) &&
		(ent.minute == item_q.minute) &&
		((ent.repeat_mask == '0) || day_hit || ent.repeat_mask[ama_pkg::ONCE_BIT]);
	assign once_only = (ent.repeat_mask != '0) && !day_hit &&
		ent.repeat_mask[ama_pkg::ONCE_BIT];

	always_comb begin
		new_ent.enabled = item_q.entry_enabled;
		new_ent.hour = item_q.hour;
		new_ent.minute = item_q.minute;
		new_ent.repeat_mask = item_q.entry_repeat;
		dis_ent = ent;
		dis_ent.enabled = 1'b0;
	end

	// The table takes either a write request or the disable of a fired once alarm.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = AW'(item_q.entry_index);
		wr_data = new_ent;
		if (cmd.exec && write_ok) begin
			wr_en = 1'b1;
		end else if (cmd.take_hit && once_only) begin
			wr_en = 1'b1;
			wr_addr = AW'(chk_q);
			wr_data = dis_ent;
		end
	end

	assign rd_en = cmd.scan_step && issue_lt;

	ama_ram #(
		.WIDTH(ama_pkg::ENTRY_W),
		.DEPTH(MAX_ALARMS),
		.AW(AW)
	) u_table (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(AW'(issue_q)),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ringing_q <= 1'b0;
			slot_q <= '0;
			rd_vld_q <= 1'b0;
			issue_q <= '0;
		end else begin
			if (cmd.exec) begin
				issue_q <= '0;
				rd_vld_q <= 1'b0;
				if (item_q.opcode == ama_pkg::OP_STOP) begin
					ringing_q <= 1'b0;
					slot_q <= '0;
				end
			end
			if (cmd.scan_step) begin
				issue_q <= issue_lt ? issue_q + 1'b1 : issue_q;
				rd_vld_q <= issue_lt;
			end
			if (cmd.take_hit) begin
				ringing_q <= 1'b1;
				slot_q <= chk_q[ama_pkg::SLOT_W-1:0];
				rd_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			fired_q <= 1'b0;
			wake_q <= 1'b0;
			save_q <= 1'b0;
			show_q <= ring_tick;
			sound_q <= ring_tick && !item_q.audio_playing;
		end
		if (cmd.scan_step) begin
			chk_q <= issue_q;
		end
		if (cmd.take_hit) begin
			fired_q <= 1'b1;
			wake_q <= !item_q.screen_on;
			save_q <= once_only;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.commit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.alarm_active <= ringing_q;
			out_q.active_index <= ringing_q ? slot_q : '0;
			out_q.fired <= fired_q;
			out_q.wake_screen <= wake_q;
			out_q.play_sound <= sound_q;
			out_q.show_alarm <= show_q;
			out_q.save_request <= save_q;
		end
	end

	assign sts.need_scan = is_tick && !ringing_q && item_q.time_valid &&
		(item_q.second == '0);
	assign sts.hit = rd_vld_q && ent_match;
	assign sts.scan_end = !rd_vld_q && !issue_lt;
	assign sts.out_free = !out_vld_q || !out_stall;

	assign out_valid = out_vld_q;
	assign out_data = out_q;

endmodule

// ===== src/ama_ctrl.sv =====
// Controller: sequences accept, decode, table scan and result hand-off.
module ama_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ama_pkg::ctl_sts_t sts,
	output ama_pkg::ctl_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECODE = 4'b0010,
		S_SCAN   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.exec = 1'b1;
				state_nxt = sts.need_scan ? S_SCAN : S_FINISH;
			end
			S_SCAN: begin
				priority if (sts.hit) begin
					cmd.take_hit = 1'b1;
					state_nxt = S_FINISH;
				end else if (sts.scan_end) begin
					state_nxt = S_FINISH;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule
